/* hdl/pefs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pefs_pkg
// Shared types and constants for the power and environment fault supervisor:
// channel numbering, thresholds, per-channel limits, caps and action masks.
// ----------------------------------------------------------------------------
package pefs_pkg;

  localparam int NCHAN = 10;
  localparam int CNT_W = 5;

  // Channel numbers
  localparam int CH_MAINS_HIGH = 0;
  localparam int CH_MAINS_LOW  = 1;
  localparam int CH_MBAT_HIGH  = 2;
  localparam int CH_MBAT_LOW   = 3;
  localparam int CH_SBAT_HIGH  = 4;
  localparam int CH_SBAT_LOW   = 5;
  localparam int CH_SYS_TEMP   = 6;
  localparam int CH_BAT_TEMP   = 7;
  localparam int CH_SUP_TEMP   = 8;
  localparam int CH_FIRE       = 9;

  // Configuration register indexes
  localparam logic [1:0] REG_FAN_MARGIN     = 2'd0;
  localparam logic [1:0] REG_RAIN_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_RAIN_RUNS      = 2'd2;
  localparam logic [1:0] REG_RAIN_HOLD      = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  FAN_MARGIN_RST     = 8'd25;
  localparam logic [11:0] RAIN_THRESHOLD_RST = 12'd1018;
  localparam logic [3:0]  RAIN_RUNS_RST      = 4'd10;
  localparam logic [9:0]  RAIN_HOLD_RST      = 10'd300;

  // Mains thresholds, volts
  localparam logic [8:0] MAINS_HIGH_V  = 9'd265;
  localparam logic [8:0] MAINS_LOW_MIN = 9'd90;
  localparam logic [8:0] MAINS_LOW_MAX = 9'd200;

  // Battery thresholds, millivolts
  localparam logic [14:0] MBAT_HIGH_MV = 15'd17000;
  localparam logic [14:0] MBAT_LOW_MV  = 15'd12000;
  localparam logic [14:0] SBAT_HIGH_MV = 15'd6000;
  localparam logic [14:0] SBAT_LOW_MV  = 15'd3200;

  // Temperature thresholds, tenths of a degree C
  localparam logic signed [11:0] SYS_TEMP_MAX  = 12'sd390;
  localparam logic signed [11:0] BAT_TEMP_MAX  = 12'sd360;
  localparam logic signed [11:0] SUP_TEMP_MAX  = 12'sd370;
  localparam logic signed [11:0] FIRE_SYS_TEMP = 12'sd400;
  localparam logic signed [11:0] FIRE_BAT_TEMP = 12'sd450;
  localparam logic signed [11:0] FIRE_SUP_TEMP = 12'sd400;

  localparam logic [3:0] WET_RUN_MAX = 4'd15;

  // Per-channel latch limit and counter cap, channel 0 first
  localparam logic [CNT_W-1:0] CHAN_LIMIT [NCHAN] = '{
    5'd8, 5'd8, 5'd6, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd6, 5'd18
  };
  localparam logic [CNT_W-1:0] CHAN_CAP [NCHAN] = '{
    5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd20
  };

  // Action masks, bit per channel
  localparam logic [NCHAN-1:0] RELAY_ENGAGE_MASK  = 10'b00_0001_0111;
  localparam logic [NCHAN-1:0] RELAY_RELEASE_MASK = 10'b00_0001_0111;
  localparam logic [NCHAN-1:0] LEDS_OFF_MASK      = 10'b11_1101_1100;
  localparam logic [NCHAN-1:0] POWER_CUT_MASK     = 10'b10_0000_0001;

  // Actions requested by the fault channels in one tick
  typedef struct packed {
    logic relay_wr;   // some channel wrote the relay level
    logic relay_val;  // last level written
    logic power_cut;
    logic leds_off;
  } pefs_fault_act_t;

endpackage

/* hdl/pefs_cond.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pefs_cond
// Threshold compares for one sample set: the ten fault conditions and the
// fan decision.
// ----------------------------------------------------------------------------
module pefs_cond
  import pefs_pkg::*;
(
  input  logic [8:0]         mains_volts,
  input  logic [14:0]        main_batt_mv,
  input  logic [14:0]        sys_batt_mv,
  input  logic signed [11:0] system_temp,
  input  logic signed [11:0] battery_temp,
  input  logic signed [11:0] supply_temp,
  input  logic [7:0]         fan_margin,
  output logic [NCHAN-1:0]   cond,
  output logic               fan_on
);

  logic signed [13:0] sys_x;
  logic signed [13:0] sup_plus_margin;

  // Fan: system temp above supply temp plus margin, in 14-bit signed
  assign sys_x           = 14'(system_temp);
  assign sup_plus_margin = 14'(supply_temp) + $signed({6'd0, fan_margin});
  assign fan_on          = sys_x > sup_plus_margin;

  // Fault conditions
  always_comb begin
    cond                = '0;
    cond[CH_MAINS_HIGH] = mains_volts > MAINS_HIGH_V;
    cond[CH_MAINS_LOW]  = (mains_volts > MAINS_LOW_MIN) && (mains_volts < MAINS_LOW_MAX);
    cond[CH_MBAT_HIGH]  = main_batt_mv > MBAT_HIGH_MV;
    cond[CH_MBAT_LOW]   = main_batt_mv < MBAT_LOW_MV;
    cond[CH_SBAT_HIGH]  = sys_batt_mv > SBAT_HIGH_MV;
    cond[CH_SBAT_LOW]   = sys_batt_mv < SBAT_LOW_MV;
    cond[CH_SYS_TEMP]   = system_temp > SYS_TEMP_MAX;
    cond[CH_BAT_TEMP]   = battery_temp > BAT_TEMP_MAX;
    cond[CH_SUP_TEMP]   = supply_temp > SUP_TEMP_MAX;
    cond[CH_FIRE]       = (system_temp > FIRE_SYS_TEMP) || (battery_temp > FIRE_BAT_TEMP) ||
                          (supply_temp > FIRE_SUP_TEMP);
  end

endmodule

/* hdl/pefs_fault_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pefs_fault_bank
// Ten fault channels, each a saturating run counter and a latch. Computes the
// next state and the actions of this tick; state moves when advance is high.
// ----------------------------------------------------------------------------
module pefs_fault_bank
  import pefs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [NCHAN-1:0] cond,
  output logic [NCHAN-1:0] latched_next,
  output logic [NCHAN-1:0] alarm_next,
  output pefs_fault_act_t  act
);

  logic [CNT_W-1:0] cnt      [NCHAN];
  logic [CNT_W-1:0] cnt_next [NCHAN];
  logic [NCHAN-1:0] latched;
  logic [NCHAN-1:0] latch_evt;
  logic [NCHAN-1:0] clear_evt;

  // Per-channel counter and latch update
  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      cnt_next[c]  = cnt[c];
      latch_evt[c] = 1'b0;
      clear_evt[c] = 1'b0;
      if (cond[c]) begin
        if (cnt[c] < CHAN_CAP[c]) begin
          cnt_next[c] = cnt[c] + 1'b1;
        end
        latch_evt[c] = (cnt_next[c] >= CHAN_LIMIT[c]) && !latched[c];
      end else if (latched[c]) begin
        cnt_next[c]  = '0;
        clear_evt[c] = 1'b1;
      end
      alarm_next[c] = cnt_next[c] >= CHAN_LIMIT[c];
    end
  end

  assign latched_next = (latched | latch_evt) & ~clear_evt;

  // Actions; relay writes go in channel order so the last one wins
  always_comb begin
    act           = '0;
    act.power_cut = |(latch_evt & POWER_CUT_MASK);
    act.leds_off  = |(latch_evt & LEDS_OFF_MASK);
    for (int c = 0; c < NCHAN; c++) begin
      if (latch_evt[c] && RELAY_ENGAGE_MASK[c]) begin
        act.relay_wr  = 1'b1;
        act.relay_val = 1'b0;
      end else if (clear_evt[c] && RELAY_RELEASE_MASK[c]) begin
        act.relay_wr  = 1'b1;
        act.relay_val = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      latched <= '0;
      for (int c = 0; c < NCHAN; c++) begin
        cnt[c] <= '0;
      end
    end else if (advance) begin
      latched <= latched_next;
      for (int c = 0; c < NCHAN; c++) begin
        cnt[c] <= cnt_next[c];
      end
    end
  end

  // A latch event is never lost by the state update
  a_latch_taken: assert property (@(posedge clk) disable iff (rst)
    advance |=> ((latched & $past(latch_evt)) == $past(latch_evt)))
    else $error("latch event not recorded");

  // Latches only move with an accepted item
  a_latch_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(latched))
    else $error("latches changed without an item");

  // A fault latches only on a true condition
  a_latch_cond: assert property (@(posedge clk) disable iff (rst)
    (latch_evt & ~cond) == '0)
    else $error("latch event without its condition");

endmodule

/* hdl/pefs_rain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pefs_rain
// Wet-run detector, rain hold timer and the protect relay level. The fault
// channels' relay write is applied first, then the hold timer overrides it.
// ----------------------------------------------------------------------------
module pefs_rain
  import pefs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [11:0]     rain_level,
  input  logic [11:0]     rain_level_threshold,
  input  logic [3:0]      rain_detect_runs,
  input  logic [9:0]      rain_hold_ticks,
  input  pefs_fault_act_t act,
  output logic            relay_next,
  output logic            flag_next
);

  logic [3:0] wet_cnt;
  logic [3:0] wet_cnt_next;
  logic [9:0] hold;
  logic [9:0] hold_mid;
  logic [9:0] hold_next;
  logic       flag;
  logic       relay_level;
  logic       wet;

  // Wet run count and hold timer load
  always_comb begin
    wet = rain_level < rain_level_threshold;
    if (!wet) begin
      wet_cnt_next = '0;
    end else if (wet_cnt == WET_RUN_MAX) begin
      wet_cnt_next = wet_cnt;
    end else begin
      wet_cnt_next = wet_cnt + 1'b1;
    end
    hold_mid = (wet && (wet_cnt_next > rain_detect_runs)) ? rain_hold_ticks : hold;
  end

  // Relay level: fault write, then rain hold override
  always_comb begin
    relay_next = act.relay_wr ? act.relay_val : relay_level;
    flag_next  = 1'b0;
    hold_next  = '0;
    if (hold_mid != '0) begin
      relay_next = 1'b0;
      flag_next  = 1'b1;
      hold_next  = hold_mid - 1'b1;
    end else if (flag) begin
      relay_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wet_cnt     <= '0;
      hold        <= '0;
      flag        <= 1'b0;
      relay_level <= 1'b1;
    end else if (advance) begin
      wet_cnt     <= wet_cnt_next;
      hold        <= hold_next;
      flag        <= flag_next;
      relay_level <= relay_next;
    end
  end

  // While the rain hold is active the relay stays engaged
  a_flag_relay: assert property (@(posedge clk) disable iff (rst)
    flag |-> !relay_level)
    else $error("rain hold active with relay released");

  // A running hold timer always has the flag set
  a_hold_flag: assert property (@(posedge clk) disable iff (rst)
    (hold != '0) |-> flag)
    else $error("hold timer running without flag");

endmodule

/* hdl/power_env_fault_supervisor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_env_fault_supervisor
// Power and environment fault supervisor: ten fault channels, fan control,
// protect relay level and rain hold timer, one result item per sample item.
// ----------------------------------------------------------------------------
// The block takes one sample item per clock while in_ready is high and gives one
// result item per item, in order. An item waits in the input register and then
// lands in the result register once that register is empty or its result is taken;
// the result is valid from then on and is taken when the output side is ready. The
// supervisor state (run counters, latches, wet count, hold timer, relay level)
// updates on the same edge that an item moves to the result register, so the
// sustained rate is one item per cycle while the output side is ready. A held
// result stalls the input only once the input register is also full.
// Configuration writes take effect at once and are meant for an idle block.
module power_env_fault_supervisor
  import pefs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  // sample items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [8:0]         mains_volts,
  input  logic [14:0]        main_batt_mv,
  input  logic [14:0]        sys_batt_mv,
  input  logic signed [11:0] system_temp,
  input  logic signed [11:0] battery_temp,
  input  logic signed [11:0] supply_temp,
  input  logic [11:0]        rain_level,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               fan_on,
  output logic               protect_relay_level,
  output logic               power_cut_pulse,
  output logic               leds_off,
  output logic [NCHAN-1:0]   alarm_active,
  output logic [NCHAN-1:0]   latched_faults,
  output logic               rain_protect
);

  logic [7:0]         fan_margin;
  logic [11:0]        rain_level_threshold;
  logic [3:0]         rain_detect_runs;
  logic [9:0]         rain_hold_ticks;

  logic               s1_valid;
  logic [8:0]         s1_mains;
  logic [14:0]        s1_mbat;
  logic [14:0]        s1_sbat;
  logic signed [11:0] s1_st;
  logic signed [11:0] s1_bt;
  logic signed [11:0] s1_et;
  logic [11:0]        s1_rain;
  logic               advance;

  logic [NCHAN-1:0]   cond;
  logic               fan_next;
  logic [NCHAN-1:0]   latched_next;
  logic [NCHAN-1:0]   alarm_next;
  pefs_fault_act_t    act;
  logic               relay_next;
  logic               flag_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_margin           <= FAN_MARGIN_RST;
      rain_level_threshold <= RAIN_THRESHOLD_RST;
      rain_detect_runs     <= RAIN_RUNS_RST;
      rain_hold_ticks      <= RAIN_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAN_MARGIN:     fan_margin           <= cfg_data[7:0];
        REG_RAIN_THRESHOLD: rain_level_threshold <= cfg_data;
        REG_RAIN_RUNS:      rain_detect_runs     <= cfg_data[3:0];
        REG_RAIN_HOLD:      rain_hold_ticks      <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: input register drains into the result register
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mains <= mains_volts;
      s1_mbat  <= main_batt_mv;
      s1_sbat  <= sys_batt_mv;
      s1_st    <= system_temp;
      s1_bt    <= battery_temp;
      s1_et    <= supply_temp;
      s1_rain  <= rain_level;
    end
  end

  pefs_cond u_cond (
    .mains_volts  (s1_mains),
    .main_batt_mv (s1_mbat),
    .sys_batt_mv  (s1_sbat),
    .system_temp  (s1_st),
    .battery_temp (s1_bt),
    .supply_temp  (s1_et),
    .fan_margin   (fan_margin),
    .cond         (cond),
    .fan_on       (fan_next)
  );

  pefs_fault_bank u_bank (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cond         (cond),
    .latched_next (latched_next),
    .alarm_next   (alarm_next),
    .act          (act)
  );

  pefs_rain u_rain (
    .clk                  (clk),
    .rst                  (rst),
    .advance              (advance),
    .rain_level           (s1_rain),
    .rain_level_threshold (rain_level_threshold),
    .rain_detect_runs     (rain_detect_runs),
    .rain_hold_ticks      (rain_hold_ticks),
    .act                  (act),
    .relay_next           (relay_next),
    .flag_next            (flag_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fan_on              <= fan_next;
      protect_relay_level <= relay_next;
      power_cut_pulse     <= act.power_cut;
      leds_off            <= act.leds_off;
      alarm_active        <= alarm_next;
      latched_faults      <= latched_next;
      rain_protect        <= flag_next;
    end
  end

  // An empty result register never blocks the input
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A new result only comes from a full input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without an item");

  // A held result is never overwritten
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("held result overwritten");

endmodule
